@@ design/byte_stuffing_frame_encoder_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef BYTE_STUFFING_FRAME_ENCODER_TOP_ASSERT_SVH
`define BYTE_STUFFING_FRAME_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BSFE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsfe assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BSFE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsfe assertion failed");

`endif

@@ design/bsfe_pkg.sv @@
`default_nettype none

package bsfe_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FLAG    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL0   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL1   = 3'd5;

	localparam logic [BYTE_W-1:0] RST_FLAG    = 8'h7E;
	localparam logic [BYTE_W-1:0] RST_ESCAPE  = 8'h7D;
	localparam logic [BYTE_W-1:0] RST_MASK    = 8'h20;
	localparam logic [BYTE_W-1:0] RST_ADDRESS = 8'h03;
	localparam logic [BYTE_W-1:0] RST_CTRL0   = 8'h00;
	localparam logic [BYTE_W-1:0] RST_CTRL1   = 8'h40;
	localparam logic [BYTE_W-1:0] CHECK_INIT  = 8'h00;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [BYTE_W-1:0] flag;
		logic [BYTE_W-1:0] escape;
		logic [BYTE_W-1:0] mask;
		logic [BYTE_W-1:0] address;
		logic [BYTE_W-1:0] ctrl0;
		logic [BYTE_W-1:0] ctrl1;
	} cfg_t;

	// One classified payload byte on its way to the emitter.
	typedef struct packed {
		logic              first;
		logic              seq;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic [BYTE_W-1:0] check;
	} cmd_t;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_FLAG     = 10'b00_0000_0010,
		ST_ADDR     = 10'b00_0000_0100,
		ST_CTRL     = 10'b00_0000_1000,
		ST_HCS      = 10'b00_0001_0000,
		ST_DATA     = 10'b00_0010_0000,
		ST_DATA_ESC = 10'b00_0100_0000,
		ST_CHK      = 10'b00_1000_0000,
		ST_CHK_ESC  = 10'b01_0000_0000,
		ST_CLOSE    = 10'b10_0000_0000
	} emit_state_t;

endpackage

`default_nettype wire

@@ design/bsfe_if.sv @@
`default_nettype none

interface bsfe_in_if;
	logic                         valid;
	logic                         ready;
	logic [bsfe_pkg::BYTE_W-1:0]  payload_byte;
	logic                         sequence_bit;
	logic                         payload_last;

	modport source (output valid, payload_byte, sequence_bit, payload_last, input ready);
	modport sink   (input valid, payload_byte, sequence_bit, payload_last, output ready);
endinterface

interface bsfe_out_if;
	logic                         valid;
	logic                         ready;
	logic [bsfe_pkg::BYTE_W-1:0]  line_byte;
	logic                         frame_end;
	logic                         run_last;

	modport source (output valid, line_byte, frame_end, run_last, input ready);
	modport sink   (input valid, line_byte, frame_end, run_last, output ready);
endinterface

`default_nettype wire

@@ design/byte_stuffing_frame_encoder_top.sv @@
// Byte-stuffing frame encoder.
// payload (sink): one raw byte per transaction with its sequence bit and a
//   last-of-frame mark. The first byte of a frame is preceded on the line by
//   flag, address, control and header check; the last byte is followed by the
//   stuffed XOR check and a closing flag.
// line (source): one output byte per transaction; frame_end marks the
//   closing flag, run_last marks the final byte caused by a payload byte.
// cfg_we/cfg_index/cfg_data: register writes, index 0..5 as flag, escape,
//   mask, address, control for sequence 0 and 1; other indexes are ignored.
//   Write only while no transaction is in flight.
// The first line byte of a payload transaction passes the queue, the emitter
//   state register and the output register when the emitter is free.
// Throughput: the emitter drives one line byte per cycle while the line sink
//   is ready; a payload byte gives one line byte, two when escaped, up to nine
//   on a one-byte frame. A two-entry queue between classifier and emitter
//   keeps the input taking bytes while the emitter works.
// Reset clears the frame state, the queue and the output valid flag, and loads
//   the default register values. When the line sink stalls, the current byte
//   holds, the emitter pauses and payload is refused once the queue fills.
`default_nettype none

module byte_stuffing_frame_encoder_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bsfe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bsfe_pkg::BYTE_W-1:0]        cfg_data,
	bsfe_in_if.sink                                 payload,
	bsfe_out_if.source                              line
);

	bsfe_pkg::cfg_t  cfg_q;
	bsfe_pkg::cmd_t  push_cmd;
	bsfe_pkg::cmd_t  pop_cmd;
	logic            push;
	logic            full;
	logic            pop;
	logic            pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag    <= bsfe_pkg::RST_FLAG;
			cfg_q.escape  <= bsfe_pkg::RST_ESCAPE;
			cfg_q.mask    <= bsfe_pkg::RST_MASK;
			cfg_q.address <= bsfe_pkg::RST_ADDRESS;
			cfg_q.ctrl0   <= bsfe_pkg::RST_CTRL0;
			cfg_q.ctrl1   <= bsfe_pkg::RST_CTRL1;
		end else if (cfg_we) begin
			case (cfg_index)
				bsfe_pkg::REG_FLAG:    cfg_q.flag    <= cfg_data;
				bsfe_pkg::REG_ESCAPE:  cfg_q.escape  <= cfg_data;
				bsfe_pkg::REG_MASK:    cfg_q.mask    <= cfg_data;
				bsfe_pkg::REG_ADDRESS: cfg_q.address <= cfg_data;
				bsfe_pkg::REG_CTRL0:   cfg_q.ctrl0   <= cfg_data;
				bsfe_pkg::REG_CTRL1:   cfg_q.ctrl1   <= cfg_data;
				default: ;
			endcase
		end
	end

	bsfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.payload  (payload),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	bsfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	bsfe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (pop_valid),
		.q_cmd   (pop_cmd),
		.pop     (pop),
		.line    (line)
	);

endmodule

`default_nettype wire

@@ design/bsfe_front.sv @@
`default_nettype none

module bsfe_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bsfe_in_if.sink            payload,
	input  wire logic          full,
	output logic               push,
	output bsfe_pkg::cmd_t     push_cmd
);

	logic                         inside_q;
	logic [bsfe_pkg::BYTE_W-1:0]  check_q;
	logic [bsfe_pkg::BYTE_W-1:0]  check_new;

	assign payload.ready = !full;
	assign push = payload.valid && !full;

	assign check_new = (inside_q ? check_q : bsfe_pkg::CHECK_INIT) ^ payload.payload_byte;

	always_comb begin
		push_cmd.first = !inside_q;
		push_cmd.seq   = payload.sequence_bit;
		push_cmd.data  = payload.payload_byte;
		push_cmd.last  = payload.payload_last;
		push_cmd.check = check_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			check_q  <= bsfe_pkg::CHECK_INIT;
		end else if (push) begin
			inside_q <= !payload.payload_last;
			check_q  <= payload.payload_last ? bsfe_pkg::CHECK_INIT : check_new;
		end
	end

endmodule

`default_nettype wire

@@ design/bsfe_queue.sv @@
`default_nettype none

module bsfe_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire bsfe_pkg::cmd_t  push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 pop_valid,
	output bsfe_pkg::cmd_t       pop_cmd
);

	bsfe_pkg::cmd_t                entries_q [bsfe_pkg::QUEUE_DEPTH];
	logic [bsfe_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [bsfe_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [bsfe_pkg::QCNT_W-1:0]   count_q;

	assign full      = (count_q == bsfe_pkg::QCNT_W'(bsfe_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = entries_q[rd_ptr_q];

	function automatic logic [bsfe_pkg::QPTR_W-1:0] ptr_inc(input logic [bsfe_pkg::QPTR_W-1:0] p);
		if (p == bsfe_pkg::QPTR_W'(bsfe_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ design/bsfe_back.sv @@
`default_nettype none

module bsfe_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bsfe_pkg::cfg_t  cfg,
	input  wire logic            q_valid,
	input  wire bsfe_pkg::cmd_t  q_cmd,
	output logic                 pop,
	bsfe_out_if.source           line
);

	bsfe_pkg::emit_state_t        state_q;
	bsfe_pkg::emit_state_t        state_next;
	bsfe_pkg::cmd_t               cmd_q;
	logic                         out_valid_q;
	logic [bsfe_pkg::BYTE_W-1:0]  out_byte_q;
	logic                         out_end_q;
	logic                         out_last_q;

	logic                         busy;
	logic                         adv;
	logic                         done;
	logic                         load;
	logic [bsfe_pkg::BYTE_W-1:0]  emit_byte;
	logic                         emit_end;
	logic [bsfe_pkg::BYTE_W-1:0]  ctrl;
	logic                         data_hit;
	logic                         chk_hit;

	assign busy = (state_q != bsfe_pkg::ST_IDLE);
	assign adv  = busy && (!out_valid_q || line.ready);
	assign load = q_valid && (!busy || (adv && done));
	assign pop  = load;

	assign ctrl     = cmd_q.seq ? cfg.ctrl1 : cfg.ctrl0;
	assign data_hit = (cmd_q.data == cfg.flag) || (cmd_q.data == cfg.escape);
	assign chk_hit  = (cmd_q.check == cfg.flag) || (cmd_q.check == cfg.escape);

	always_comb begin
		emit_byte  = cfg.flag;
		emit_end   = 1'b0;
		done       = 1'b0;
		state_next = bsfe_pkg::ST_IDLE;
		case (state_q)
			bsfe_pkg::ST_FLAG: begin
				emit_byte  = cfg.flag;
				state_next = bsfe_pkg::ST_ADDR;
			end
			bsfe_pkg::ST_ADDR: begin
				emit_byte  = cfg.address;
				state_next = bsfe_pkg::ST_CTRL;
			end
			bsfe_pkg::ST_CTRL: begin
				emit_byte  = ctrl;
				state_next = bsfe_pkg::ST_HCS;
			end
			bsfe_pkg::ST_HCS: begin
				emit_byte  = ctrl ^ cfg.address;
				state_next = bsfe_pkg::ST_DATA;
			end
			bsfe_pkg::ST_DATA: begin
				if (data_hit) begin
					emit_byte  = cfg.escape;
					state_next = bsfe_pkg::ST_DATA_ESC;
				end else begin
					emit_byte  = cmd_q.data;
					state_next = bsfe_pkg::ST_CHK;
					done       = !cmd_q.last;
				end
			end
			bsfe_pkg::ST_DATA_ESC: begin
				emit_byte  = cmd_q.data ^ cfg.mask;
				state_next = bsfe_pkg::ST_CHK;
				done       = !cmd_q.last;
			end
			bsfe_pkg::ST_CHK: begin
				if (chk_hit) begin
					emit_byte  = cfg.escape;
					state_next = bsfe_pkg::ST_CHK_ESC;
				end else begin
					emit_byte  = cmd_q.check;
					state_next = bsfe_pkg::ST_CLOSE;
				end
			end
			bsfe_pkg::ST_CHK_ESC: begin
				emit_byte  = cmd_q.check ^ cfg.mask;
				state_next = bsfe_pkg::ST_CLOSE;
			end
			bsfe_pkg::ST_CLOSE: begin
				emit_byte = cfg.flag;
				emit_end  = 1'b1;
				done      = 1'b1;
			end
			default: begin
				emit_byte  = cfg.flag;
				state_next = bsfe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsfe_pkg::ST_IDLE;
		end else if (load) begin
			state_q <= q_cmd.first ? bsfe_pkg::ST_FLAG : bsfe_pkg::ST_DATA;
		end else if (adv) begin
			state_q <= done ? bsfe_pkg::ST_IDLE : state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			cmd_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (line.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= emit_byte;
			out_end_q  <= emit_end;
			out_last_q <= done;
		end
	end

	assign line.valid     = out_valid_q;
	assign line.line_byte = out_byte_q;
	assign line.frame_end = out_end_q;
	assign line.run_last  = out_last_q;

endmodule

`default_nettype wire

@@ design/bsfe_checker.sv @@
`default_nettype none

`include "byte_stuffing_frame_encoder_top_assert.svh"

module bsfe_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          line_valid,
	input  wire logic                          line_ready,
	input  wire logic [bsfe_pkg::BYTE_W-1:0]   line_byte,
	input  wire logic                          frame_end,
	input  wire logic                          run_last
);

	`BSFE_ASSERT_NEXT(a_stall_hold, line_valid && !line_ready, line_valid && $stable(line_byte) && $stable(frame_end) && $stable(run_last))
	`BSFE_ASSERT_NOW(a_end_is_last, line_valid && frame_end, run_last)
	`BSFE_ASSERT_NOW(a_quiet_after_reset, $rose(arst_n), !line_valid)

endmodule

bind byte_stuffing_frame_encoder_top bsfe_checker u_bsfe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.line_valid (line.valid),
	.line_ready (line.ready),
	.line_byte  (line.line_byte),
	.frame_end  (line.frame_end),
	.run_last   (line.run_last)
);

`default_nettype wire

@@ verif/tb_byte_stuffing_frame_encoder_top.sv @@
`timescale 1ns / 1ps

module tb_byte_stuffing_frame_encoder_top;
	import bsfe_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 24;
	localparam int MAX_REPORTS = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic [BYTE_W-1:0] line_byte;
		logic              frame_end;
		logic              run_last;
	} line_beat_t;

	class frame_scoreboard;
		cfg_t              regs;
		bit                in_frame;
		logic [BYTE_W-1:0] payload_xor;
		line_beat_t        line_due[$];
		int                errors;

		function void clear();
			regs.flag    = RST_FLAG;
			regs.escape  = RST_ESCAPE;
			regs.mask    = RST_MASK;
			regs.address = RST_ADDRESS;
			regs.ctrl0   = RST_CTRL0;
			regs.ctrl1   = RST_CTRL1;
			in_frame     = 1'b0;
			payload_xor  = CHECK_INIT;
			errors       = 0;
			line_due.delete();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
			case (idx)
				REG_FLAG:    regs.flag = val;
				REG_ESCAPE:  regs.escape = val;
				REG_MASK:    regs.mask = val;
				REG_ADDRESS: regs.address = val;
				REG_CTRL0:   regs.ctrl0 = val;
				REG_CTRL1:   regs.ctrl1 = val;
				default: ;
			endcase
		endfunction

		function void push_beat(logic [BYTE_W-1:0] b, logic fe);
			line_beat_t e;
			e.line_byte = b;
			e.frame_end = fe;
			e.run_last  = 1'b0;
			line_due.push_back(e);
		endfunction

		function void push_stuffed(logic [BYTE_W-1:0] b);
			if (b == regs.escape || b == regs.flag) begin
				push_beat(regs.escape, 1'b0);
				push_beat(b ^ regs.mask, 1'b0);
			end else begin
				push_beat(b, 1'b0);
			end
		endfunction

		// Expected line bytes for one accepted payload transaction.
		function void note_payload(logic [BYTE_W-1:0] data, logic seq, logic last);
			logic [BYTE_W-1:0] ctrl;
			line_beat_t        tail;
			if (!in_frame) begin
				ctrl = seq ? regs.ctrl1 : regs.ctrl0;
				push_beat(regs.flag, 1'b0);
				push_beat(regs.address, 1'b0);
				push_beat(ctrl, 1'b0);
				push_beat(ctrl ^ regs.address, 1'b0);
				in_frame    = 1'b1;
				payload_xor = CHECK_INIT;
			end
			payload_xor = payload_xor ^ data;
			push_stuffed(data);
			if (last) begin
				push_stuffed(payload_xor);
				push_beat(regs.flag, 1'b1);
				in_frame    = 1'b0;
				payload_xor = CHECK_INIT;
			end
			tail = line_due.pop_back();
			tail.run_last = 1'b1;
			line_due.push_back(tail);
		endfunction

		function void check_line(logic [BYTE_W-1:0] b, logic fe, logic rl);
			line_beat_t e;
			if (line_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("tb: unexpected line byte %02h frame_end %0b run_last %0b",
						b, fe, rl);
				return;
			end
			e = line_due.pop_front();
			if (b !== e.line_byte || fe !== e.frame_end || rl !== e.run_last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("tb: line mismatch exp %02h/%0b/%0b got %02h/%0b/%0b",
						e.line_byte, e.frame_end, e.run_last, b, fe, rl);
			end
		endfunction

		function int pending();
			return line_due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;

	bsfe_in_if  payload_if();
	bsfe_out_if line_if();

	frame_scoreboard frame_sb;
	int              idle_cycles;
	bit              send_burst;
	bit              recv_burst;
	int              frame_left;

	byte_stuffing_frame_encoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.payload   (payload_if),
		.line      (line_if)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((payload_if.valid && payload_if.ready) || (line_if.valid && line_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// line sink with random stalls
	initial begin
		int gap;
		int beats;
		beats = 0;
		recv_burst = 1'b0;
		line_if.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (beats % 48 == 0) recv_burst = ($urandom_range(0, 3) == 0);
			gap = recv_burst ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				line_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			line_if.ready <= 1'b1;
			@(posedge clk);
			while (!line_if.valid) @(posedge clk);
			frame_sb.check_line(line_if.line_byte, line_if.frame_end, line_if.run_last);
			beats++;
		end
	end

	task automatic send_payload(input logic [BYTE_W-1:0] data, input logic seq,
			input logic last);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			payload_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		payload_if.valid        <= 1'b1;
		payload_if.payload_byte <= data;
		payload_if.sequence_bit <= seq;
		payload_if.payload_last <= last;
		@(posedge clk);
		while (!payload_if.ready) @(posedge clk);
		frame_sb.note_payload(data, seq, last);
	endtask

	task automatic wait_drained();
		payload_if.valid <= 1'b0;
		@(posedge clk);
		while (frame_sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		frame_sb.write_reg(idx, val);
	endtask

	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic apply_settings(input logic [BYTE_W-1:0] flag, input logic [BYTE_W-1:0] esc,
			input logic [BYTE_W-1:0] mask, input logic [BYTE_W-1:0] addr,
			input logic [BYTE_W-1:0] c0, input logic [BYTE_W-1:0] c1);
		write_reg(REG_FLAG, flag);
		write_reg(REG_ESCAPE, esc);
		write_reg(REG_MASK, mask);
		write_reg(REG_ADDRESS, addr);
		write_reg(REG_CTRL0, c0);
		write_reg(REG_CTRL1, c1);
		write_reg(REG_SPARE_LO, rand_byte());
		write_reg(REG_SPARE_HI, rand_byte());
		cfg_we <= 1'b0;
	endtask

	// bias toward bytes that need stuffing
	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1:    return frame_sb.regs.flag;
			2, 3:    return frame_sb.regs.escape;
			4:       return frame_sb.regs.flag ^ frame_sb.regs.mask;
			5:       return 8'h00;
			6:       return 8'hFF;
			default: return rand_byte();
		endcase
	endfunction

	// frames may stay open across calls, so settings also change mid-frame
	task automatic run_random(input int count);
		logic [BYTE_W-1:0] data;
		logic              last;
		for (int n = 0; n < count; n++) begin
			if (n % 30 == 0) send_burst = ($urandom_range(0, 3) == 0);
			if (frame_left == 0)
				frame_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
					: $urandom_range(1, 5);
			data = pick_byte();
			last = (frame_left == 1);
			frame_left--;
			send_payload(data, 1'($urandom_range(0, 1)), last);
			if (n == count / 2) wait_drained();
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] shared;
		frame_sb = new();
		frame_sb.clear();
		send_burst = 1'b0;
		frame_left = 0;
		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= REG_FLAG;
		cfg_data                <= '0;
		payload_if.valid        <= 1'b0;
		payload_if.payload_byte <= '0;
		payload_if.sequence_bit <= 1'b0;
		payload_if.payload_last <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// one-byte frames
		send_payload(8'h00, 1'b0, 1'b1);
		send_payload(8'hFF, 1'b1, 1'b1);
		send_payload(RST_FLAG, 1'b1, 1'b1);
		send_payload(RST_ESCAPE, 1'b0, 1'b1);
		// seq toggles mid-frame, check ends up needing escape
		send_payload(RST_FLAG, 1'b0, 1'b0);
		send_payload(RST_ESCAPE, 1'b1, 1'b0);
		send_payload(8'h5E, 1'b0, 1'b0);
		send_payload(8'h20, 1'b1, 1'b1);
		// check equals flag
		send_payload(8'h7C, 1'b1, 1'b0);
		send_payload(8'h02, 1'b0, 1'b1);
		send_payload(8'h55, 1'b0, 1'b0);
		send_payload(8'hAA, 1'b1, 1'b0);
		send_payload(8'h01, 1'b0, 1'b1);
		// flag changed while a frame is open
		send_payload(8'h11, 1'b0, 1'b0);
		wait_drained();
		write_reg(REG_FLAG, 8'h11);
		cfg_we <= 1'b0;
		send_payload(8'h11, 1'b1, 1'b0);
		send_payload(8'h22, 1'b0, 1'b1);
		run_random(60);

		wait_drained();
		apply_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		run_random(65);

		wait_drained();
		apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		run_random(65);

		wait_drained();
		shared = rand_byte();
		apply_settings(shared, shared, rand_byte(), rand_byte(), rand_byte(), rand_byte());
		run_random(65);

		wait_drained();
		apply_settings(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
			rand_byte());
		run_random(65);

		wait_drained();
		apply_settings(RST_FLAG, RST_ESCAPE, RST_MASK, RST_ADDRESS, RST_CTRL0, RST_CTRL1);
		run_random(73);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (frame_sb.pending() != 0) frame_sb.errors++;
		if (frame_sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
